// ===== src/assert_macros.svh =====
// Assertion macros for the checker in abp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ABP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

// Checked on every rising edge, reset included.
`define ABP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

// ===== src/abp_pkg.sv =====
package abp_pkg;

    typedef enum logic [1:0] {
        FMT_XRGB32 = 2'd0,
        FMT_RGB24  = 2'd1,
        FMT_RGB555 = 2'd2,
        FMT_NONE   = 2'd3
    } t_dest_fmt;

    localparam int unsigned NUM_LANES = 3;

    localparam logic [31:0] RB_MASK    = 32'h00FF_00FF;
    localparam logic [31:0] G_MASK     = 32'h0000_FF00;
    localparam logic [31:0] TOP_MASK   = 32'hFF00_0000;

    typedef struct packed {
        logic mul_en;
        logic add_en;
    } t_lane_ctl;

endpackage

// ===== src/abp_ifs.sv =====
interface abp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] src_pixel;
    logic [31:0] dst_word;

    modport source (output valid, output src_pixel, output dst_word, input ready);
    modport sink (input valid, input src_pixel, input dst_word, output ready);
endinterface

interface abp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_word;
    logic        written;

    modport source (output valid, output out_word, output written, input ready);
    modport sink (input valid, input out_word, input written, output ready);
endinterface

// ===== src/abp_lane.sv =====
module abp_lane (
    input  logic                  i_clk,
    input  abp_pkg::t_lane_ctl    i_ctl,
    input  logic [31:0]           i_diff,
    input  logic [31:0]           i_dval,
    input  logic [8:0]            i_weight,
    output logic [31:0]           o_sum
);

    logic [31:0] r_prod;
    logic [31:0] r_dval;
    logic [31:0] r_sum;
    logic [31:0] n_prod;
    logic [31:0] n_sum;

    // The product wraps modulo 2^32, as the packed lanes rely on.
    always_comb begin
        n_prod = i_diff * {23'd0, i_weight};
        n_sum  = {8'd0, r_prod[31:8]} + r_dval;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= n_prod;
            r_dval <= i_dval;
        end
        if (i_ctl.add_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== src/alpha_blend_pixel_multiformat.sv =====
// Alpha blender for one framebuffer pixel per clock unless the output stalls.
// The input channel carries a source pixel (alpha 31-24, blue 23-16, green 15-8,
// red 7-0) and the current destination word; the output channel returns the
// blended destination word and a flag that is low when the format is unsupported,
// in which case the destination word comes back unchanged.
// The format register is written through i_cfg_we and i_cfg_data; the user must
// write it only while no pixel is in flight, as the block does not enforce this.
// Each pixel takes the format that stands when it is accepted. A pixel passes
// operand select and subtract, multiply by alpha plus one, add, then repacking
// into the output register. While the output does not stall, a new pixel may
// come in every cycle; throughput is set by the one multiplier per channel lane.
// Each stage holds its valid bit and advances when the stage after it is empty
// or advancing, so a stalled receiver holds the result in the output register
// while bubbles further up still fill; nothing is lost or repeated.
// A synchronous reset empties the pipeline and sets the format to 32-bit xRGB.
module alpha_blend_pixel_multiformat (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_data,
    abp_in_if.sink           i_pix,
    abp_out_if.source        o_pix
);

    localparam int unsigned NL = abp_pkg::NUM_LANES;

    abp_pkg::t_dest_fmt r_fmt;

    logic en1, en2, en3, en4;
    logic r_v1, r_v2, r_v3, r_ov;

    logic [31:0] n_diff [NL];
    logic [31:0] n_dval [NL];
    logic [31:0] r1_diff [NL];
    logic [31:0] r1_dval [NL];
    logic [31:0] lane_sum [NL];
    logic [8:0]  r1_weight;

    abp_pkg::t_dest_fmt r1_fmt, r2_fmt, r3_fmt;
    logic [31:0] r1_dst, r2_dst, r3_dst;

    logic [31:0] r_out_word;
    logic        r_written;
    logic [31:0] n_out_word;
    logic        n_written;

    abp_pkg::t_lane_ctl lane_ctl;

    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] sx;
    logic [31:0] s_op [NL];

    always_comb begin
        en4 = !r_ov || o_pix.ready;
        en3 = !r_v3 || en4;
        en2 = !r_v2 || en3;
        en1 = !r_v1 || en2;
        lane_ctl.mul_en = en2;
        lane_ctl.add_en = en3;
    end

    assign i_pix.ready = en1;

    always_comb begin
        src = i_pix.src_pixel;
        dst = i_pix.dst_word;
        sx  = {8'd0, src[7:0], src[15:8], src[23:16]};
        for (int i = 0; i < NL; i++) begin
            s_op[i]   = '0;
            n_dval[i] = '0;
        end
        unique case (r_fmt)
            abp_pkg::FMT_XRGB32: begin
                s_op[0]   = sx & abp_pkg::RB_MASK;
                n_dval[0] = dst & abp_pkg::RB_MASK;
                s_op[1]   = sx & abp_pkg::G_MASK;
                n_dval[1] = dst & abp_pkg::G_MASK;
            end
            abp_pkg::FMT_RGB24: begin
                s_op[0]   = {24'd0, src[23:16]};
                n_dval[0] = {24'd0, dst[7:0]};
                s_op[1]   = {24'd0, src[15:8]};
                n_dval[1] = {24'd0, dst[15:8]};
                s_op[2]   = {24'd0, src[7:0]};
                n_dval[2] = {24'd0, dst[23:16]};
            end
            abp_pkg::FMT_RGB555: begin
                s_op[0]   = {24'd0, src[23:16]};
                n_dval[0] = {24'd0, dst[4:0], 3'd0};
                s_op[1]   = {24'd0, src[15:8]};
                n_dval[1] = {24'd0, dst[9:5], 3'd0};
                s_op[2]   = {24'd0, src[7:0]};
                n_dval[2] = {24'd0, dst[14:10], 3'd0};
            end
            default: begin
            end
        endcase
        for (int i = 0; i < NL; i++) begin
            n_diff[i] = s_op[i] - n_dval[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= abp_pkg::FMT_XRGB32;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fmt <= abp_pkg::t_dest_fmt'(i_cfg_data);
            end
            if (en1) begin
                r_v1 <= i_pix.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_ov <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            for (int i = 0; i < NL; i++) begin
                r1_diff[i] <= n_diff[i];
                r1_dval[i] <= n_dval[i];
            end
            r1_weight <= {1'b0, src[31:24]} + 9'd1;
            r1_fmt    <= r_fmt;
            r1_dst    <= dst;
        end
        if (en2) begin
            r2_fmt <= r1_fmt;
            r2_dst <= r1_dst;
        end
        if (en3) begin
            r3_fmt <= r2_fmt;
            r3_dst <= r2_dst;
        end
        if (en4) begin
            r_out_word <= n_out_word;
            r_written  <= n_written;
        end
    end

    for (genvar g = 0; g < NL; g++) begin : g_lane
        abp_lane u_lane (
            .i_clk    (i_clk),
            .i_ctl    (lane_ctl),
            .i_diff   (r1_diff[g]),
            .i_dval   (r1_dval[g]),
            .i_weight (r1_weight),
            .o_sum    (lane_sum[g])
        );
    end

    always_comb begin
        n_out_word = r3_dst;
        n_written  = 1'b1;
        unique case (r3_fmt)
            abp_pkg::FMT_XRGB32: begin
                n_out_word = (lane_sum[0] & abp_pkg::RB_MASK)
                           | (lane_sum[1] & abp_pkg::G_MASK);
            end
            abp_pkg::FMT_RGB24: begin
                n_out_word = (r3_dst & abp_pkg::TOP_MASK)
                           | {8'd0, lane_sum[2][7:0], lane_sum[1][7:0], lane_sum[0][7:0]};
            end
            abp_pkg::FMT_RGB555: begin
                n_out_word = {r3_dst[31:16], 1'b0, lane_sum[2][7:3],
                              lane_sum[1][7:3], lane_sum[0][7:3]};
            end
            default: begin
                n_written = 1'b0;
            end
        endcase
    end

    assign o_pix.valid    = r_ov;
    assign o_pix.out_word = r_out_word;
    assign o_pix.written  = r_written;

endmodule

// ===== src/abp_checker.sv =====
`include "assert_macros.svh"

module abp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_word,
    input logic        i_out_written
);

    logic in_xfer;

    assign in_xfer = i_in_valid && i_in_ready;

    `ABP_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> !i_out_valid)

    `ABP_ASSERT(a_hold_valid, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)

    `ABP_ASSERT(a_hold_data, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> $stable(i_out_word) && $stable(i_out_written))

    `ABP_ASSERT(a_latency, i_clk, i_rst_n, in_xfer ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready |=> i_out_valid)

endmodule

bind alpha_blend_pixel_multiformat abp_checker u_abp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_pix.valid),
    .i_in_ready    (i_pix.ready),
    .i_out_valid   (o_pix.valid),
    .i_out_ready   (o_pix.ready),
    .i_out_word    (o_pix.out_word),
    .i_out_written (o_pix.written)
);

// ===== test/tb_top.sv =====
module tb_top;

    typedef struct packed {
        logic [31:0] out_word;
        logic        written;
    } t_blend_res;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          HOLD_CYCLES = 300;
    localparam int          PRINT_LIMIT = 40;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_data;

    abp_in_if  pix_in ();
    abp_out_if pix_out ();

    alpha_blend_pixel_multiformat u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in),
        .o_pix      (pix_out)
    );

    t_blend_res          expected_blends[$];
    abp_pkg::t_dest_fmt  cur_fmt = abp_pkg::FMT_XRGB32;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b1;
    int          hold_requests = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          recv_mode = 0;
    int          recv_phase = 0;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] mix_channel(input logic [31:0] s, input logic [31:0] d,
                                               input logic [31:0] w);
        logic [31:0] p;
        p = (((s - d) * w) >> 8) + d;
        return p[7:0];
    endfunction

    function automatic t_blend_res blend_pixel(input abp_pkg::t_dest_fmt fmt,
                                               input logic [31:0] s,
                                               input logic [31:0] d);
        t_blend_res  r;
        logic [31:0] w;
        logic [31:0] sx;
        logic [31:0] xrb;
        logic [31:0] xg;
        logic [7:0]  nb;
        logic [7:0]  ng;
        logic [7:0]  nr;
        w = {24'd0, s[31:24]} + 32'd1;
        r.out_word = d;
        r.written = 1'b1;
        case (fmt)
            abp_pkg::FMT_XRGB32: begin
                // Red and blue swap places so that red lands in bits 23-16.
                sx = {8'd0, s[7:0], s[15:8], s[23:16]};
                xrb = ((sx & abp_pkg::RB_MASK) - (d & abp_pkg::RB_MASK)) * w;
                xg = ((sx & abp_pkg::G_MASK) - (d & abp_pkg::G_MASK)) * w;
                r.out_word = (((xrb >> 8) + (d & abp_pkg::RB_MASK)) & abp_pkg::RB_MASK)
                           | (((xg >> 8) + (d & abp_pkg::G_MASK)) & abp_pkg::G_MASK);
            end
            abp_pkg::FMT_RGB24: begin
                nb = mix_channel({24'd0, s[23:16]}, {24'd0, d[7:0]}, w);
                ng = mix_channel({24'd0, s[15:8]}, {24'd0, d[15:8]}, w);
                nr = mix_channel({24'd0, s[7:0]}, {24'd0, d[23:16]}, w);
                r.out_word = {d[31:24], nr, ng, nb};
            end
            abp_pkg::FMT_RGB555: begin
                nb = mix_channel({24'd0, s[23:16]}, {24'd0, d[4:0], 3'b000}, w);
                ng = mix_channel({24'd0, s[15:8]}, {24'd0, d[9:5], 3'b000}, w);
                nr = mix_channel({24'd0, s[7:0]}, {24'd0, d[14:10], 3'b000}, w);
                r.out_word = {d[31:16], 1'b0, nr[7:3], ng[7:3], nb[7:3]};
            end
            default: r.written = 1'b0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("mismatch: %s, expected %h, got %h", what, want, got);
    endtask

    // The receiver changes its stall pattern every so often; a requested
    // hold-off overrides it and holds ready low.
    always @(negedge i_clk) begin
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (recv_phase == 0) begin
            recv_mode = $urandom_range(0, 3);
            recv_phase = $urandom_range(16, 160);
        end
        recv_phase--;
        if (hold_left > 0) begin
            hold_left--;
            pix_out.ready <= 1'b0;
        end else begin
            case (recv_mode)
                0: pix_out.ready <= 1'b1;
                1: pix_out.ready <= 1'($urandom_range(0, 1));
                2: pix_out.ready <= ($urandom_range(0, 9) != 0);
                default: pix_out.ready <= ((recv_phase % 4) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_blend_res want;
        if (i_rst_n && pix_out.valid === 1'b1 && pix_out.ready === 1'b1) begin
            if (expected_blends.size() == 0) begin
                report_mismatch("result transfer with no pixel outstanding", '0,
                                pix_out.out_word);
            end else begin
                want = expected_blends.pop_front();
                if (pix_out.out_word !== want.out_word)
                    report_mismatch("out_word", want.out_word, pix_out.out_word);
                if (pix_out.written !== want.written)
                    report_mismatch("written", {31'd0, want.written},
                                    {31'd0, pix_out.written});
            end
        end
    end

    task automatic send_pixel(input logic [31:0] src, input logic [31:0] dst);
        int gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk);
            pix_in.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        pix_in.valid <= 1'b1;
        pix_in.src_pixel <= src;
        pix_in.dst_word <= dst;
        do @(posedge i_clk); while (pix_in.ready !== 1'b1);
        expected_blends.push_back(blend_pixel(cur_fmt, src, dst));
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        pix_in.valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic set_format(input abp_pkg::t_dest_fmt fmt);
        stop_sending();
        while (expected_blends.size() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= fmt;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_fmt = fmt;
    endtask

    function automatic logic [31:0] random_source();
        logic [31:0] s;
        int          sel;
        s = $urandom();
        sel = $urandom_range(0, 5);
        if (sel == 0)
            s[31:24] = 8'h00;
        else if (sel == 1)
            s[31:24] = 8'hFF;
        return s;
    endfunction

    task automatic test_directed();
        logic [31:0]        srcs[6];
        logic [31:0]        dsts[6];
        abp_pkg::t_dest_fmt fmts[4];
        srcs = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFF12_3456,
                 32'h80FF_00FF, 32'h7F00_FF00, 32'h0180_4020};
        dsts = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hA5A5_A5A5,
                 32'hFF00_FF00, 32'h80FF_00FF, 32'hFFFF_8000};
        fmts = '{abp_pkg::FMT_XRGB32, abp_pkg::FMT_RGB24,
                 abp_pkg::FMT_RGB555, abp_pkg::FMT_NONE};
        gaps_on = 1'b1;
        foreach (fmts[f]) begin
            set_format(fmts[f]);
            foreach (srcs[i])
                send_pixel(srcs[i], dsts[i]);
        end
    endtask

    // The receiver stops for a long stretch while the sender keeps offering,
    // so the pipeline fills and the input transfer stalls.
    task automatic test_backpressure();
        set_format(abp_pkg::FMT_RGB24);
        gaps_on = 1'b0;
        @(posedge i_clk);
        hold_requests++;
        repeat (60) send_pixel(random_source(), $urandom());
    endtask

    task automatic test_random();
        abp_pkg::t_dest_fmt fmt;
        for (int phase = 0; phase < 8; phase++) begin
            if (phase < 4)
                fmt = abp_pkg::t_dest_fmt'(phase[1:0]);
            else
                fmt = abp_pkg::t_dest_fmt'($urandom_range(0, 3));
            set_format(fmt);
            gaps_on = ($urandom_range(0, 3) != 0);
            repeat (250) send_pixel(random_source(), $urandom());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = abp_pkg::FMT_XRGB32;
        pix_in.valid = 1'b0;
        pix_in.src_pixel = '0;
        pix_in.dst_word = '0;
        pix_out.ready = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random();

        stop_sending();
        for (int k = 0; k < 2000 && expected_blends.size() != 0; k++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (expected_blends.size() != 0)
            report_mismatch("pixels without a result", expected_blends.size(), '0);

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
